FILE: rtl/hrhp_pkg.sv
// shared constants, character codes, name words and result type of the http request header parser
package hrhp_pkg;

  localparam int DEF_MAX_MESSAGE_BYTES = 4096;
  localparam int DEF_LENGTH_BITS       = 24;

  localparam int BYTE_BITS   = 8;
  localparam int OFF_BITS    = 12;
  localparam int CLEN_BITS   = 24;
  localparam int TBC_BITS    = 13;
  localparam int VIDX_BITS   = 4;
  localparam int STATUS_BITS = 2;

  localparam logic [OFF_BITS-1:0] OFF_MAX = '1;
  localparam logic [OFF_BITS-1:0] HOST_SKIP = OFF_BITS'(6);

  localparam logic [BYTE_BITS-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_BITS-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_BITS-1:0] CH_SP    = 8'h20;
  localparam logic [BYTE_BITS-1:0] CH_COLON = 8'h3A;
  localparam logic [BYTE_BITS-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_BITS-1:0] CH_NINE  = 8'h39;

  localparam int GET_LEN  = 3;
  localparam int HOST_LEN = 4;
  localparam int CONN_LEN = 10;
  localparam int CLEN_LEN = 14;
  localparam int KA_LEN   = 10;

  localparam logic [0:3][BYTE_BITS-1:0]  WORD_GET  = {"GET", 8'h00};
  localparam logic [0:3][BYTE_BITS-1:0]  WORD_HOST = "Host";
  localparam logic [0:15][BYTE_BITS-1:0] WORD_CONN = {"Connection", 48'h0};
  localparam logic [0:15][BYTE_BITS-1:0] WORD_CLEN = {"Content-Length", 16'h0};
  localparam logic [0:15][BYTE_BITS-1:0] WORD_KA   = {"keep-alive", 48'h0};

  typedef enum logic [STATUS_BITS-1:0] {
    ST_INCOMPLETE = 2'd0,
    ST_COMPLETE   = 2'd1,
    ST_BROKEN     = 2'd2
  } status_t;

  typedef struct packed {
    status_t               status;
    logic                  is_get;
    logic                  keep_alive;
    logic [CLEN_BITS-1:0]  content_length;
    logic [OFF_BITS-1:0]   url_offset;
    logic [OFF_BITS-1:0]   url_length;
    logic [OFF_BITS-1:0]   host_offset;
    logic [OFF_BITS-1:0]   host_length;
    logic [OFF_BITS-1:0]   body_offset;
  } result_t;

endpackage

FILE: rtl/http_request_header_parser_core.sv
// http request header parser: byte-wise request line, header and body tracking with result buffer
//
// channel  dir  handshake            payload
// in       in   in_valid/in_stall    data_byte, first_byte, buffer_end
// out      out  out_valid/out_stall  status, is_get, keep_alive, content_length,
//                                    url_offset, url_length, host_offset,
//                                    host_length, body_offset
//
// one byte per cycle while in_stall is low; the parse state updates on the cycle the byte transfers
// a byte with buffer_end has its result registered in the output register, or in the skid entry if the output is held
// the output register plus one skid entry hold results; input stalls only when both are full
// synchronous reset returns the parser to the request line and empties the result buffer
module http_request_header_parser_core #(
  parameter int MAX_MESSAGE_BYTES = hrhp_pkg::DEF_MAX_MESSAGE_BYTES,
  parameter int LENGTH_BITS       = hrhp_pkg::DEF_LENGTH_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [hrhp_pkg::BYTE_BITS-1:0]      data_byte,
  input  logic                                first_byte,
  input  logic                                buffer_end,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [hrhp_pkg::STATUS_BITS-1:0]    status,
  output logic                                is_get,
  output logic                                keep_alive,
  output logic [hrhp_pkg::CLEN_BITS-1:0]      content_length,
  output logic [hrhp_pkg::OFF_BITS-1:0]       url_offset,
  output logic [hrhp_pkg::OFF_BITS-1:0]       url_length,
  output logic [hrhp_pkg::OFF_BITS-1:0]       host_offset,
  output logic [hrhp_pkg::OFF_BITS-1:0]       host_length,
  output logic [hrhp_pkg::OFF_BITS-1:0]       body_offset
);
  import hrhp_pkg::*;

  localparam int POS_BITS = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam int ACC_BITS = LENGTH_BITS + 4;
  localparam int CMP_BITS = (POS_BITS > LENGTH_BITS) ? POS_BITS : LENGTH_BITS;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

  typedef enum logic [1:0] {
    PH_REQUEST,
    PH_HEADER,
    PH_BODY,
    PH_BROKEN
  } phase_t;

  phase_t                 phase, phase_next;
  logic [POS_BITS-1:0]    byte_position, byte_position_next;
  logic [1:0]             token_count, token_count_next;
  logic [TBC_BITS-1:0]    token_byte_count, token_byte_count_next;
  logic                   method_match, method_match_next;
  logic                   method_is_get, method_is_get_next;
  logic [OFF_BITS-1:0]    url_start, url_start_next;
  logic [OFF_BITS-1:0]    url_len, url_len_next;
  logic [OFF_BITS-1:0]    line_start, line_start_next;
  logic [2:0]             name_match_flags, name_match_flags_next;
  logic                   past_colon, past_colon_next;
  logic [VIDX_BITS-1:0]   value_index, value_index_next;
  logic                   keep_alive_pending, keep_alive_pending_next;
  logic                   keep_alive_flag, keep_alive_flag_next;
  logic [LENGTH_BITS-1:0] length_pending, length_pending_next;
  logic [LENGTH_BITS-1:0] length_value, length_value_next;
  logic [OFF_BITS-1:0]    host_start, host_start_next;
  logic [OFF_BITS-1:0]    host_len, host_len_next;
  logic [POS_BITS-1:0]    body_count, body_count_next;
  logic                   prev_cr, prev_cr_next;
  logic [OFF_BITS-1:0]    body_start, body_start_next;

  logic [POS_BITS-1:0]    pos;
  logic [TBC_BITS-1:0]    vlen;
  logic [ACC_BITS-1:0]    acc;
  logic                   in_xfer;
  logic                   out_xfer;
  logic                   produce;
  result_t                res_new;
  result_t                res;
  result_t                skid;
  logic                   skid_valid;

  assign in_stall = skid_valid;
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;
  assign produce  = in_xfer && buffer_end;

  always_comb begin
    if (first_byte) begin
      phase_next              = PH_REQUEST;
      byte_position_next      = '0;
      token_count_next        = '0;
      token_byte_count_next   = '0;
      method_match_next       = 1'b1;
      method_is_get_next      = 1'b0;
      url_start_next          = '0;
      url_len_next            = '0;
      line_start_next         = '0;
      name_match_flags_next   = '1;
      past_colon_next         = 1'b0;
      value_index_next        = '0;
      keep_alive_pending_next = 1'b1;
      keep_alive_flag_next    = 1'b0;
      length_pending_next     = '0;
      length_value_next       = '0;
      host_start_next         = '0;
      host_len_next           = '0;
      body_count_next         = '0;
      prev_cr_next            = 1'b0;
      body_start_next         = '0;
    end else begin
      phase_next              = phase;
      byte_position_next      = byte_position;
      token_count_next        = token_count;
      token_byte_count_next   = token_byte_count;
      method_match_next       = method_match;
      method_is_get_next      = method_is_get;
      url_start_next          = url_start;
      url_len_next            = url_len;
      line_start_next         = line_start;
      name_match_flags_next   = name_match_flags;
      past_colon_next         = past_colon;
      value_index_next        = value_index;
      keep_alive_pending_next = keep_alive_pending;
      keep_alive_flag_next    = keep_alive_flag;
      length_pending_next     = length_pending;
      length_value_next       = length_value;
      host_start_next         = host_start;
      host_len_next           = host_len;
      body_count_next         = body_count;
      prev_cr_next            = prev_cr;
      body_start_next         = body_start;
    end

    pos  = byte_position_next;
    vlen = '0;
    acc  = '0;

    if (phase_next != PH_BROKEN) begin
      if (byte_position_next >= POS_BITS'(MAX_MESSAGE_BYTES)) begin
        phase_next = PH_BROKEN;
      end else begin
        byte_position_next = byte_position_next + 1'b1;
        case (phase_next)
          PH_REQUEST: begin
            if (data_byte == CH_SP || data_byte == CH_LF) begin
              if (token_byte_count_next == '0 || token_count_next == 2'd3) begin
                phase_next = PH_BROKEN;
              end else begin
                if (token_count_next == 2'd0) begin
                  method_is_get_next = method_match_next &&
                                       (token_byte_count_next == TBC_BITS'(GET_LEN));
                end else if (token_count_next == 2'd1) begin
                  url_len_next = (token_byte_count_next > TBC_BITS'(OFF_MAX)) ?
                                 OFF_MAX : OFF_BITS'(token_byte_count_next);
                end
                token_count_next      = token_count_next + 1'b1;
                token_byte_count_next = '0;
                if (data_byte == CH_LF) begin
                  phase_next              = PH_HEADER;
                  line_start_next         = OFF_BITS'(pos + 1'b1);
                  name_match_flags_next   = '1;
                  past_colon_next         = 1'b0;
                  value_index_next        = '0;
                  keep_alive_pending_next = 1'b1;
                  length_pending_next     = '0;
                  prev_cr_next            = 1'b0;
                end
              end
            end else begin
              if (token_count_next == 2'd0) begin
                if (token_byte_count_next >= TBC_BITS'(GET_LEN) ||
                    data_byte != WORD_GET[token_byte_count_next[1:0]]) begin
                  method_match_next = 1'b0;
                end
              end else if (token_count_next == 2'd1 && token_byte_count_next == '0) begin
                url_start_next = OFF_BITS'(pos);
              end
              if (token_byte_count_next != '1) begin
                token_byte_count_next = token_byte_count_next + 1'b1;
              end
            end
          end
          PH_HEADER: begin
            if (data_byte == CH_LF) begin
              if (!past_colon_next && token_byte_count_next == TBC_BITS'(1) && prev_cr_next) begin
                phase_next      = PH_BODY;
                body_start_next = OFF_BITS'(pos + 1'b1);
                body_count_next = '0;
              end else begin
                if (past_colon_next) begin
                  vlen = (token_byte_count_next != '0) ? token_byte_count_next - 1'b1 : '0;
                  if (name_match_flags_next[0]) begin
                    host_start_next = line_start_next + HOST_SKIP;
                    host_len_next   = (vlen > TBC_BITS'(OFF_MAX)) ? OFF_MAX : OFF_BITS'(vlen);
                  end else if (name_match_flags_next[1]) begin
                    keep_alive_flag_next = keep_alive_pending_next;
                  end else if (name_match_flags_next[2]) begin
                    length_value_next = length_pending_next;
                  end
                end
                line_start_next         = OFF_BITS'(pos + 1'b1);
                token_byte_count_next   = '0;
                name_match_flags_next   = '1;
                past_colon_next         = 1'b0;
                value_index_next        = '0;
                keep_alive_pending_next = 1'b1;
                length_pending_next     = '0;
                prev_cr_next            = 1'b0;
              end
            end else begin
              if (!past_colon_next) begin
                if (data_byte == CH_COLON) begin
                  if (token_byte_count_next != TBC_BITS'(HOST_LEN)) name_match_flags_next[0] = 1'b0;
                  if (token_byte_count_next != TBC_BITS'(CONN_LEN)) name_match_flags_next[1] = 1'b0;
                  if (token_byte_count_next != TBC_BITS'(CLEN_LEN)) name_match_flags_next[2] = 1'b0;
                  past_colon_next         = 1'b1;
                  token_byte_count_next   = '0;
                  value_index_next        = '0;
                  keep_alive_pending_next = 1'b1;
                  length_pending_next     = '0;
                end else begin
                  if (!(token_byte_count_next < TBC_BITS'(HOST_LEN) &&
                        data_byte == WORD_HOST[token_byte_count_next[1:0]])) begin
                    name_match_flags_next[0] = 1'b0;
                  end
                  if (!(token_byte_count_next < TBC_BITS'(CONN_LEN) &&
                        data_byte == WORD_CONN[token_byte_count_next[3:0]])) begin
                    name_match_flags_next[1] = 1'b0;
                  end
                  if (!(token_byte_count_next < TBC_BITS'(CLEN_LEN) &&
                        data_byte == WORD_CLEN[token_byte_count_next[3:0]])) begin
                    name_match_flags_next[2] = 1'b0;
                  end
                  if (token_byte_count_next != '1) begin
                    token_byte_count_next = token_byte_count_next + 1'b1;
                  end
                end
              end else begin
                if (token_byte_count_next != '0) begin
                  if (name_match_flags_next[1]) begin
                    if (value_index_next < VIDX_BITS'(KA_LEN)) begin
                      if (data_byte != WORD_KA[value_index_next]) begin
                        keep_alive_pending_next = 1'b0;
                      end
                      value_index_next = value_index_next + 1'b1;
                    end
                  end else if (name_match_flags_next[2] && keep_alive_pending_next) begin
                    if (data_byte >= CH_ZERO && data_byte <= CH_NINE) begin
                      acc = (ACC_BITS'(length_pending_next) << 3) +
                            (ACC_BITS'(length_pending_next) << 1) +
                            ACC_BITS'(data_byte - CH_ZERO);
                      length_pending_next = (acc > ACC_BITS'(LEN_MAX)) ?
                                            LEN_MAX : LENGTH_BITS'(acc);
                    end else begin
                      keep_alive_pending_next = 1'b0;
                    end
                  end
                end
                if (token_byte_count_next != '1) begin
                  token_byte_count_next = token_byte_count_next + 1'b1;
                end
              end
              prev_cr_next = (data_byte == CH_CR);
            end
          end
          PH_BODY: begin
            body_count_next = body_count_next + 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    if (phase_next == PH_BROKEN) begin
      res_new.status = ST_BROKEN;
    end else if (phase_next != PH_BODY) begin
      res_new.status = ST_INCOMPLETE;
    end else if (CMP_BITS'(body_count_next) < CMP_BITS'(length_value_next)) begin
      res_new.status = ST_INCOMPLETE;
    end else if (CMP_BITS'(body_count_next) == CMP_BITS'(length_value_next)) begin
      res_new.status = ST_COMPLETE;
    end else begin
      res_new.status = ST_BROKEN;
    end
    res_new.is_get         = method_is_get_next;
    res_new.keep_alive     = keep_alive_flag_next;
    res_new.content_length = CLEN_BITS'(length_value_next);
    res_new.url_offset     = url_start_next;
    res_new.url_length     = url_len_next;
    res_new.host_offset    = host_start_next;
    res_new.host_length    = host_len_next;
    res_new.body_offset    = body_start_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_REQUEST;
      byte_position      <= '0;
      token_count        <= '0;
      token_byte_count   <= '0;
      method_match       <= 1'b1;
      method_is_get      <= 1'b0;
      url_start          <= '0;
      url_len            <= '0;
      line_start         <= '0;
      name_match_flags   <= '1;
      past_colon         <= 1'b0;
      value_index        <= '0;
      keep_alive_pending <= 1'b1;
      keep_alive_flag    <= 1'b0;
      length_pending     <= '0;
      length_value       <= '0;
      host_start         <= '0;
      host_len           <= '0;
      body_count         <= '0;
      prev_cr            <= 1'b0;
      body_start         <= '0;
    end else if (in_xfer) begin
      phase              <= phase_next;
      byte_position      <= byte_position_next;
      token_count        <= token_count_next;
      token_byte_count   <= token_byte_count_next;
      method_match       <= method_match_next;
      method_is_get      <= method_is_get_next;
      url_start          <= url_start_next;
      url_len            <= url_len_next;
      line_start         <= line_start_next;
      name_match_flags   <= name_match_flags_next;
      past_colon         <= past_colon_next;
      value_index        <= value_index_next;
      keep_alive_pending <= keep_alive_pending_next;
      keep_alive_flag    <= keep_alive_flag_next;
      length_pending     <= length_pending_next;
      length_value       <= length_value_next;
      host_start         <= host_start_next;
      host_len           <= host_len_next;
      body_count         <= body_count_next;
      prev_cr            <= prev_cr_next;
      body_start         <= body_start_next;
    end
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_xfer) begin
      if (skid_valid) begin
        res        <= skid;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
        if (produce) begin
          skid       <= res_new;
          skid_valid <= 1'b1;
        end
      end else if (produce) begin
        res       <= res_new;
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (produce) begin
      skid       <= res_new;
      skid_valid <= 1'b1;
    end
  end

  assign status         = res.status;
  assign is_get         = res.is_get;
  assign keep_alive     = res.keep_alive;
  assign content_length = res.content_length;
  assign url_offset     = res.url_offset;
  assign url_length     = res.url_length;
  assign host_offset    = res.host_offset;
  assign host_length    = res.host_length;
  assign body_offset    = res.body_offset;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while output register empty");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    produce |=> out_valid)
    else $error("buffer end transfer gave no result");

  a_broken_sticks: assert property (@(posedge clk) disable iff (rst)
    in_xfer && !first_byte && phase == PH_BROKEN |=> phase == PH_BROKEN)
    else $error("broken request left broken state without restart");

  a_position_bound: assert property (@(posedge clk) disable iff (rst)
    byte_position <= POS_BITS'(MAX_MESSAGE_BYTES))
    else $error("byte position beyond message limit");

endmodule
